@@ rtl/aging_packet_fifo_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Aging packet FIFO assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AGING_PACKET_FIFO_UNIT_MACROS_SVH
`define AGING_PACKET_FIFO_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define APF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define APF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define APF_ASSERT(lbl, clk, rst_n, prop, msg)
`define APF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/apf_pkg.sv @@
// ----------------------------------------------------------------------------
// Aging packet FIFO package
// Operation codes, register indexes, reset values and the decoded op type.
// ----------------------------------------------------------------------------
package apf_pkg;

    localparam int FUNC_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int MAXENT_BITS = 9;

    localparam logic [FUNC_BITS-1:0] FUNC_ENQ   = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_DEQ   = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_PEEK  = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_FLUSH = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DELAY   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SNAP_PERIOD = 2'd2;

    localparam logic [MAXENT_BITS-1:0] MAX_ENTRIES_RST = 9'd200;
    localparam logic [63:0]            MAX_DELAY_RST   = 64'd5000000;
    localparam logic [63:0]            SNAP_PERIOD_RST = 64'd100000;

    typedef struct packed {
        logic enq;
        logic deq;
        logic peek;
        logic flush;
    } t_op;

endpackage

@@ rtl/apf_front.sv @@
// ----------------------------------------------------------------------------
// Aging packet FIFO front end
// Accepts commands, decodes the operation and buffers two items for the engine.
// ----------------------------------------------------------------------------
module apf_front import apf_pkg::*; #(
    parameter int TIME_BITS = 48,
    parameter int DESC_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [FUNC_BITS-1:0] i_func,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [DESC_BITS-1:0] i_entry_in,
    output logic                 o_valid,
    input  logic                 i_take,
    output t_op                  o_op,
    output logic [TIME_BITS-1:0] o_now,
    output logic [DESC_BITS-1:0] o_entry
);

    t_op                  r_op_q  [2];
    logic [TIME_BITS-1:0] r_now_q [2];
    logic [DESC_BITS-1:0] r_ent_q [2];
    logic                 r_wp, n_wp;
    logic                 r_rp, n_rp;
    logic [1:0]           r_cnt, n_cnt;
    t_op                  dec_op;
    logic                 push_ok;
    logic                 pop_ok;

    always_comb begin
        dec_op = '0;
        case (i_func)
            FUNC_ENQ:   dec_op.enq   = 1'b1;
            FUNC_DEQ:   dec_op.deq   = 1'b1;
            FUNC_PEEK:  dec_op.peek  = 1'b1;
            FUNC_FLUSH: dec_op.flush = 1'b1;
            default:    dec_op.flush = 1'b1;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_take && o_valid;

    assign o_op    = r_op_q[r_rp];
    assign o_now   = r_now_q[r_rp];
    assign o_entry = r_ent_q[r_rp];

    always_comb begin
        n_wp  = push_ok ? ~r_wp : r_wp;
        n_rp  = pop_ok ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_op_q[r_wp]  <= dec_op;
            r_now_q[r_wp] <= i_now;
            r_ent_q[r_wp] <= i_entry_in;
        end
    end

endmodule

@@ rtl/apf_engine.sv @@
// ----------------------------------------------------------------------------
// Aging packet FIFO engine
// Runs one command at a time against the descriptor and stamp memory.
// ----------------------------------------------------------------------------
module apf_engine import apf_pkg::*; #(
    parameter int DEPTH     = 256,
    parameter int TIME_BITS = 48,
    parameter int DESC_BITS = 32,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_take,
    input  t_op                    i_op,
    input  logic [TIME_BITS-1:0]   i_now,
    input  logic [DESC_BITS-1:0]   i_entry,
    input  logic [MAXENT_BITS-1:0] i_max_entries,
    input  logic [TIME_BITS-1:0]   i_max_delay,
    input  logic [TIME_BITS-1:0]   i_snap_period,
    output logic                   o_res_valid,
    input  logic                   i_res_full,
    output logic                   o_res_ok,
    output logic [DESC_BITS-1:0]   o_res_entry,
    output logic [TIME_BITS-1:0]   o_res_stamp,
    output logic [CNT_W-1:0]       o_res_occ,
    output logic [CNT_W-1:0]       o_res_snap,
    output logic [CNT_W-1:0]       o_res_expired
);

    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = AW + 2;
    localparam int LIM_W = (CNT_W > MAXENT_BITS) ? CNT_W : MAXENT_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_POP    = 3'd3;
    localparam logic [2:0] ST_HEAD   = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CNT_W-1:0] b);
        logic [SW-1:0] sum;
        sum = SW'(a) + SW'(b);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [DESC_BITS-1:0] r_desc_mem  [DEPTH];
    logic [TIME_BITS-1:0] r_stamp_mem [DEPTH];
    logic [DESC_BITS-1:0] r_rd_desc;
    logic [TIME_BITS-1:0] r_rd_stamp;

    logic [2:0]           r_state, n_state;
    t_op                  r_op, n_op;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [DESC_BITS-1:0] r_entry, n_entry;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [CNT_W-1:0]     r_kept, n_kept;
    logic                 r_pv, n_pv;
    logic [CNT_W-1:0]     r_snap_size, n_snap_size;
    logic [TIME_BITS-1:0] r_snap_time, n_snap_time;
    logic                 r_res_ok, n_res_ok;
    logic [DESC_BITS-1:0] r_res_entry, n_res_entry;
    logic [TIME_BITS-1:0] r_res_stamp, n_res_stamp;
    logic [CNT_W-1:0]     r_res_exp, n_res_exp;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [DESC_BITS-1:0] wr_desc;
    logic [TIME_BITS-1:0] wr_stamp;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    logic                 can_take;
    logic                 take;
    logic                 lim_ok;
    logic                 snap_due;
    logic                 rd_expired;
    logic                 scan_issue;

    assign can_take   = (r_state == ST_IDLE) || ((r_state == ST_RESULT) && !i_res_full);
    assign take       = can_take && i_cmd_valid;
    assign o_cmd_take = take;

    assign lim_ok   = (LIM_W'(r_count) < LIM_W'(i_max_entries)) &&
                      (r_count < CNT_W'(DEPTH));
    assign snap_due = (r_now > r_snap_time) && ((r_now - r_snap_time) > i_snap_period);

    // stamps later than now never expire
    assign rd_expired = (r_rd_stamp <= r_now) && ((r_now - r_rd_stamp) >= i_max_delay);
    assign scan_issue = (r_k < r_count);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_now       = r_now;
        n_entry     = r_entry;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_k         = r_k;
        n_kept      = r_kept;
        n_pv        = r_pv;
        n_snap_size = r_snap_size;
        n_snap_time = r_snap_time;
        n_res_ok    = r_res_ok;
        n_res_entry = r_res_entry;
        n_res_stamp = r_res_stamp;
        n_res_exp   = r_res_exp;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        wr_desc     = r_entry;
        wr_stamp    = r_now;
        rd_en       = 1'b0;
        rd_addr     = r_head;

        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_op    = i_op;
                    n_now   = i_now;
                    n_entry = i_entry;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res_ok    = 1'b0;
                n_res_entry = '0;
                n_res_stamp = '0;
                n_res_exp   = '0;
                if (r_op.enq) begin
                    if (snap_due) begin
                        n_snap_size = r_count;
                        n_snap_time = r_now;
                    end
                    if (lim_ok) begin
                        wr_en    = 1'b1;
                        n_tail   = wrap_add(r_tail, CNT_W'(1));
                        n_count  = r_count + CNT_W'(1);
                        n_res_ok = 1'b1;
                    end
                    n_state = ST_RESULT;
                end else if (r_op.deq) begin
                    n_k     = '0;
                    n_kept  = '0;
                    n_pv    = 1'b0;
                    n_state = ST_SCAN;
                end else if (r_op.peek) begin
                    n_state = ST_POP;
                end else begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                    n_state = ST_RESULT;
                end
            end
            ST_SCAN: begin
                // read slot k while the slot read last cycle is compacted behind it
                if (scan_issue) begin
                    rd_en   = 1'b1;
                    rd_addr = wrap_add(r_head, r_k);
                    n_k     = r_k + CNT_W'(1);
                end
                n_pv = scan_issue;
                if (r_pv && !rd_expired) begin
                    wr_en    = 1'b1;
                    wr_addr  = wrap_add(r_head, r_kept);
                    wr_desc  = r_rd_desc;
                    wr_stamp = r_rd_stamp;
                    n_kept   = r_kept + CNT_W'(1);
                end
                if (!scan_issue && !r_pv) begin
                    n_res_exp = r_count - r_kept;
                    n_count   = r_kept;
                    n_tail    = wrap_add(r_head, r_kept);
                    n_state   = ST_POP;
                end
            end
            ST_POP: begin
                if (r_count != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = ST_HEAD;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_HEAD: begin
                n_res_ok    = 1'b1;
                n_res_entry = r_rd_desc;
                n_res_stamp = r_rd_stamp;
                if (r_op.deq) begin
                    n_head  = wrap_add(r_head, CNT_W'(1));
                    n_count = r_count - CNT_W'(1);
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!i_res_full) begin
                    if (take) begin
                        n_op    = i_op;
                        n_now   = i_now;
                        n_entry = i_entry;
                        n_state = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_kept      <= '0;
            r_pv        <= 1'b0;
            r_snap_size <= '0;
            r_snap_time <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_k         <= n_k;
            r_kept      <= n_kept;
            r_pv        <= n_pv;
            r_snap_size <= n_snap_size;
            r_snap_time <= n_snap_time;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_now       <= n_now;
        r_entry     <= n_entry;
        r_res_ok    <= n_res_ok;
        r_res_entry <= n_res_entry;
        r_res_stamp <= n_res_stamp;
        r_res_exp   <= n_res_exp;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_desc_mem[wr_addr]  <= wr_desc;
            r_stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en) begin
            r_rd_desc  <= r_desc_mem[rd_addr];
            r_rd_stamp <= r_stamp_mem[rd_addr];
        end
    end

    // occupancy and snapshot are already final while the result waits
    assign o_res_valid   = (r_state == ST_RESULT);
    assign o_res_ok      = r_res_ok;
    assign o_res_entry   = r_res_entry;
    assign o_res_stamp   = r_res_stamp;
    assign o_res_occ     = r_count;
    assign o_res_snap    = r_snap_size;
    assign o_res_expired = r_res_exp;

endmodule

@@ rtl/apf_resq.sv @@
// ----------------------------------------------------------------------------
// Aging packet FIFO result queue
// Two-entry queue that holds finished results until they are popped.
// ----------------------------------------------------------------------------
module apf_resq import apf_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [W-1:0] i_data,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data [2];
    logic         r_wp, n_wp;
    logic         r_rp, n_rp;
    logic [1:0]   r_cnt, n_cnt;
    logic         push_ok;
    logic         pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_data[r_rp];

    always_comb begin
        n_wp  = push_ok ? ~r_wp : r_wp;
        n_rp  = pop_ok ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

@@ rtl/aging_packet_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// Aging packet FIFO unit
// Bounded descriptor FIFO with tail drop, time-stamped entries and expiry.
// ----------------------------------------------------------------------------
// Commands enter a two-item front queue and results leave through a two-item
// result queue, so both sides can stall independently. A dequeue sweeps every
// held entry through the descriptor memory, one read and at most one write a
// cycle, to drop expired ones and compact the rest. No clearing pass follows
// reset; the memory is only read where it was written.
module aging_packet_fifo_unit import apf_pkg::*; #(
    parameter int DEPTH     = 256,
    parameter int TIME_BITS = 48,
    parameter int DESC_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [FUNC_BITS-1:0]        i_func,
    input  logic [TIME_BITS-1:0]        i_now,
    input  logic [DESC_BITS-1:0]        i_entry_in,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_ok,
    output logic [DESC_BITS-1:0]        o_entry_out,
    output logic [TIME_BITS-1:0]        o_stamp_out,
    output logic [$clog2(DEPTH+1)-1:0]  o_occupancy,
    output logic [$clog2(DEPTH+1)-1:0]  o_size_snapshot,
    output logic [$clog2(DEPTH+1)-1:0]  o_expired_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [TIME_BITS-1:0]        i_cfg_data
);

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OFS_SNP = CNT_W;
    localparam int OFS_OCC = 2 * CNT_W;
    localparam int OFS_STP = 3 * CNT_W;
    localparam int OFS_ENT = OFS_STP + TIME_BITS;
    localparam int RW      = OFS_ENT + DESC_BITS + 1;

    logic [MAXENT_BITS-1:0] r_max_entries;
    logic [TIME_BITS-1:0]   r_max_delay;
    logic [TIME_BITS-1:0]   r_snap_period;

    logic                 cmd_valid;
    logic                 cmd_take;
    t_op                  cmd_op;
    logic [TIME_BITS-1:0] cmd_now;
    logic [DESC_BITS-1:0] cmd_entry;

    logic                 res_valid;
    logic                 res_full;
    logic                 res_ok;
    logic [DESC_BITS-1:0] res_entry;
    logic [TIME_BITS-1:0] res_stamp;
    logic [CNT_W-1:0]     res_occ;
    logic [CNT_W-1:0]     res_snap;
    logic [CNT_W-1:0]     res_exp;
    logic [RW-1:0]        res_pack;
    logic [RW-1:0]        out_pack;
    logic [CNT_W:0]       out_total;
    logic                 total_ok;
    logic                 payload_zero;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
            r_max_delay   <= TIME_BITS'(MAX_DELAY_RST);
            r_snap_period <= TIME_BITS'(SNAP_PERIOD_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[MAXENT_BITS-1:0];
                CFG_MAX_DELAY:   r_max_delay   <= i_cfg_data;
                CFG_SNAP_PERIOD: r_snap_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    apf_front #(
        .TIME_BITS (TIME_BITS),
        .DESC_BITS (DESC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_func     (i_func),
        .i_now      (i_now),
        .i_entry_in (i_entry_in),
        .o_valid    (cmd_valid),
        .i_take     (cmd_take),
        .o_op       (cmd_op),
        .o_now      (cmd_now),
        .o_entry    (cmd_entry)
    );

    apf_engine #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS),
        .DESC_BITS (DESC_BITS),
        .CNT_W     (CNT_W)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_take    (cmd_take),
        .i_op          (cmd_op),
        .i_now         (cmd_now),
        .i_entry       (cmd_entry),
        .i_max_entries (r_max_entries),
        .i_max_delay   (r_max_delay),
        .i_snap_period (r_snap_period),
        .o_res_valid   (res_valid),
        .i_res_full    (res_full),
        .o_res_ok      (res_ok),
        .o_res_entry   (res_entry),
        .o_res_stamp   (res_stamp),
        .o_res_occ     (res_occ),
        .o_res_snap    (res_snap),
        .o_res_expired (res_exp)
    );

    assign res_pack = {res_ok, res_entry, res_stamp, res_occ, res_snap, res_exp};

    apf_resq #(
        .W (RW)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .o_full  (res_full),
        .i_data  (res_pack),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (out_pack)
    );

    assign o_ok            = out_pack[RW-1];
    assign o_entry_out     = out_pack[OFS_ENT +: DESC_BITS];
    assign o_stamp_out     = out_pack[OFS_STP +: TIME_BITS];
    assign o_occupancy     = out_pack[OFS_OCC +: CNT_W];
    assign o_size_snapshot = out_pack[OFS_SNP +: CNT_W];
    assign o_expired_count = out_pack[CNT_W-1:0];

    // survivors plus expired never exceed what the memory can hold
    assign out_total    = {1'b0, o_occupancy} + {1'b0, o_expired_count};
    assign total_ok     = (out_total <= (CNT_W+1)'(DEPTH));
    assign payload_zero = (o_entry_out == '0) && (o_stamp_out == '0);

`include "aging_packet_fifo_unit_macros.svh"

    `APF_ASSERT_IMPLIES(a_res_total_bound, i_clk, i_rst_n, !empty, total_ok, "total over depth")
    `APF_ASSERT_IMPLIES(a_no_item_zero, i_clk, i_rst_n, !empty && !o_ok, payload_zero, "payload set")

endmodule
